### sv/awcp_pkg.sv
// ----------------------------------------------------------------------------
// awcp_pkg
// Shared codes, field widths and reset values for the adaptive write
// coalescing policy selector.
// ----------------------------------------------------------------------------
package awcp_pkg;

   // Field widths
   localparam int unsigned ModeWidth   = 2;
   localparam int unsigned MtuWidth    = 16;
   localparam int unsigned DelayWidth  = 24;
   localparam int unsigned HystWidth   = 4;
   localparam int unsigned SizeWidth   = 24;
   localparam int unsigned GapWidth    = 32;
   localparam int unsigned PolWidth    = 2;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrWidth    = 24;

   // EWMA weight 1/8 and gap factor 4 (as a left shift)
   localparam int unsigned EwmaShift      = 3;
   localparam int unsigned GapFactorShift = 2;

   // Register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_MODE = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_MTU  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_DLY  = 2'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_HYST = 2'd3;

   // Operating modes
   localparam logic [ModeWidth-1:0] MODE_FIXED    = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_ADAPTIVE = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_BYPASS   = 2'd2;
   localparam logic [ModeWidth-1:0] MODE_DRAIN    = 2'd3;

   // Policies
   localparam logic [PolWidth-1:0] POL_BATCH  = 2'd0;
   localparam logic [PolWidth-1:0] POL_BYPASS = 2'd1;
   localparam logic [PolWidth-1:0] POL_DRAIN  = 2'd2;

   // Item kinds
   localparam logic KIND_OBSERVE = 1'b0;
   localparam logic KIND_DECIDE  = 1'b1;

   // Register reset values
   localparam logic [ModeWidth-1:0]  RST_MODE = MODE_ADAPTIVE;
   localparam logic [MtuWidth-1:0]   RST_MTU  = 16'd1500;
   localparam logic [DelayWidth-1:0] RST_DLY  = 24'd1000;
   localparam logic [HystWidth-1:0]  RST_HYST = 4'd3;

   localparam logic [HystWidth-1:0]  STREAK_MAX = '1;

endpackage

### sv/adaptive_write_coalesce_policy.sv
// ----------------------------------------------------------------------------
// adaptive_write_coalesce_policy
// Tracks running averages of write size and inter-write gap and answers
// policy requests (batch, bypass, drain) with hysteresis in adaptive mode.
// ----------------------------------------------------------------------------
// Usage: one item is taken per cycle. Observe items update the averages at
// the edge they are accepted and give no result; a decide item gives one
// result in the output register on the following cycle. Every item is done
// in combinational logic between the input and the result register, so
// sustained throughput is one item per clock. The input is stalled only
// while a result waits in the output register and the receiver stalls.
// Configuration writes take effect at the next edge and must be made while
// the block is idle.
module adaptive_write_coalesce_policy (
   input  logic                                   clock,
   input  logic                                   reset,
   // input channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [awcp_pkg::SizeWidth-1:0]         req_write_bytes,
   input  logic [awcp_pkg::GapWidth-1:0]          req_gap_micros,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [awcp_pkg::PolWidth-1:0]          rsp_policy,
   output logic [awcp_pkg::PolWidth-1:0]          rsp_previous_policy,
   output logic                                   rsp_transitioned,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [awcp_pkg::CsrIdxWidth-1:0]       csr_index,
   input  logic [awcp_pkg::CsrWidth-1:0]          csr_data
);

   // Registers
   logic [awcp_pkg::ModeWidth-1:0]  mode_ff;
   logic [awcp_pkg::MtuWidth-1:0]   mtu_ff;
   logic [awcp_pkg::DelayWidth-1:0] dly_ff;
   logic [awcp_pkg::HystWidth-1:0]  hyst_ff;

   logic [awcp_pkg::SizeWidth-1:0]  avg_size_ff, avg_size_in;
   logic [awcp_pkg::GapWidth-1:0]   avg_gap_ff, avg_gap_in;
   logic [awcp_pkg::PolWidth-1:0]   cur_pol_ff, cur_pol_in;
   logic [awcp_pkg::PolWidth-1:0]   pend_ff, pend_in;
   logic [awcp_pkg::HystWidth-1:0]  streak_ff, streak_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [awcp_pkg::PolWidth-1:0]   rsp_pol_ff, rsp_pol_in;
   logic [awcp_pkg::PolWidth-1:0]   rsp_prev_ff;
   logic                            rsp_trans_ff, rsp_trans_in;

   logic req_xfer;
   logic obs_xfer;
   logic dec_xfer;

   // Handshake: stall only while a held result is blocked
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign obs_xfer  = req_xfer & (req_kind == awcp_pkg::KIND_OBSERVE);
   assign dec_xfer  = req_xfer & (req_kind == awcp_pkg::KIND_DECIDE);

   // EWMA updates: avg + floor((sample - avg) / 8); stays within field range
   logic signed [awcp_pkg::SizeWidth:0]   size_diff, size_step;
   logic [awcp_pkg::SizeWidth:0]          size_sum;
   logic signed [awcp_pkg::GapWidth:0]    gap_diff, gap_step;
   logic [awcp_pkg::GapWidth:0]           gap_sum;

   always_comb begin
      size_diff = $signed({1'b0, req_write_bytes}) - $signed({1'b0, avg_size_ff});
      size_step = size_diff >>> awcp_pkg::EwmaShift;
      size_sum  = {1'b0, avg_size_ff} + $unsigned(size_step);
      gap_diff  = $signed({1'b0, req_gap_micros}) - $signed({1'b0, avg_gap_ff});
      gap_step  = gap_diff >>> awcp_pkg::EwmaShift;
      gap_sum   = {1'b0, avg_gap_ff} + $unsigned(gap_step);
   end

   always_comb begin
      avg_size_in = avg_size_ff;
      avg_gap_in  = avg_gap_ff;
      if (obs_xfer) begin
         if (avg_size_ff == '0) begin
            avg_size_in = req_write_bytes;
         end else begin
            avg_size_in = size_sum[awcp_pkg::SizeWidth-1:0];
         end
         if (req_gap_micros != '0) begin
            if (avg_gap_ff == '0) begin
               avg_gap_in = req_gap_micros;
            end else begin
               avg_gap_in = gap_sum[awcp_pkg::GapWidth-1:0];
            end
         end
      end
   end

   // Candidate policy from the averages
   logic [awcp_pkg::PolWidth-1:0]  cand;
   logic [awcp_pkg::GapWidth-1:0]  gap_limit;

   assign gap_limit = {{(awcp_pkg::GapWidth - awcp_pkg::DelayWidth
                         - awcp_pkg::GapFactorShift){1'b0}},
                       dly_ff, {awcp_pkg::GapFactorShift{1'b0}}};

   always_comb begin
      if ({{(awcp_pkg::SizeWidth - awcp_pkg::MtuWidth){1'b0}}, mtu_ff} <= avg_size_ff) begin
         cand = awcp_pkg::POL_BYPASS;
      end else if (avg_gap_ff > gap_limit) begin
         cand = awcp_pkg::POL_DRAIN;
      end else begin
         cand = awcp_pkg::POL_BATCH;
      end
   end

   // Decision and hysteresis
   logic [awcp_pkg::HystWidth-1:0] streak_inc;

   assign streak_inc = (streak_ff == awcp_pkg::STREAK_MAX) ? streak_ff
                                                           : streak_ff + 1'b1;

   always_comb begin
      cur_pol_in   = cur_pol_ff;
      pend_in      = pend_ff;
      streak_in    = streak_ff;
      rsp_pol_in   = cur_pol_ff;
      rsp_trans_in = 1'b0;
      case (mode_ff)
         awcp_pkg::MODE_FIXED: begin
            rsp_pol_in = awcp_pkg::POL_BATCH;
         end
         awcp_pkg::MODE_BYPASS: begin
            rsp_pol_in = awcp_pkg::POL_BYPASS;
         end
         awcp_pkg::MODE_DRAIN: begin
            rsp_pol_in = awcp_pkg::POL_DRAIN;
         end
         awcp_pkg::MODE_ADAPTIVE: begin
            if (cand == cur_pol_ff) begin
               streak_in = '0;
            end else if (cand != pend_ff) begin
               pend_in   = cand;
               streak_in = {{(awcp_pkg::HystWidth-1){1'b0}}, 1'b1};
            end else if (streak_inc >= hyst_ff) begin
               rsp_pol_in   = cand;
               rsp_trans_in = 1'b1;
               streak_in    = '0;
            end else begin
               streak_in = streak_inc;
            end
         end
         default: begin
            rsp_pol_in = cur_pol_ff;
         end
      endcase
      cur_pol_in = rsp_pol_in;
   end

   // Result register valid
   always_comb begin
      if (dec_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= awcp_pkg::RST_MODE;
         mtu_ff       <= awcp_pkg::RST_MTU;
         dly_ff       <= awcp_pkg::RST_DLY;
         hyst_ff      <= awcp_pkg::RST_HYST;
         avg_size_ff  <= '0;
         avg_gap_ff   <= '0;
         cur_pol_ff   <= awcp_pkg::POL_BATCH;
         pend_ff      <= awcp_pkg::POL_BATCH;
         streak_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               awcp_pkg::CSR_MODE: mode_ff <= csr_data[awcp_pkg::ModeWidth-1:0];
               awcp_pkg::CSR_MTU:  mtu_ff  <= csr_data[awcp_pkg::MtuWidth-1:0];
               awcp_pkg::CSR_DLY:  dly_ff  <= csr_data[awcp_pkg::DelayWidth-1:0];
               awcp_pkg::CSR_HYST: hyst_ff <= csr_data[awcp_pkg::HystWidth-1:0];
               default: begin
               end
            endcase
         end
         avg_size_ff  <= avg_size_in;
         avg_gap_ff   <= avg_gap_in;
         if (dec_xfer) begin
            cur_pol_ff <= cur_pol_in;
            pend_ff    <= pend_in;
            streak_ff  <= streak_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (dec_xfer) begin
         rsp_pol_ff   <= rsp_pol_in;
         rsp_prev_ff  <= cur_pol_ff;
         rsp_trans_ff <= rsp_trans_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_policy          = rsp_pol_ff;
   assign rsp_previous_policy = rsp_prev_ff;
   assign rsp_transitioned    = rsp_trans_ff;

   // Assertions
   a_trans_changes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_trans_ff |-> rsp_pol_ff != rsp_prev_ff)
      else $error("transition reported without a policy change");

   a_policy_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pol_ff == awcp_pkg::POL_BATCH ||
                        rsp_pol_ff == awcp_pkg::POL_BYPASS ||
                        rsp_pol_ff == awcp_pkg::POL_DRAIN))
      else $error("illegal policy code in result");

   a_zero_gap_hold: assert property (@(posedge clock) disable iff (reset)
      obs_xfer && req_gap_micros == '0 |=> $stable(avg_gap_ff))
      else $error("gap average moved on a zero gap sample");

   a_decide_result: assert property (@(posedge clock) disable iff (reset)
      dec_xfer |=> rsp_valid_ff && rsp_pol_ff == cur_pol_ff)
      else $error("decision result missing or out of step with policy");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive write coalescing policy selector.
// A behavioral copy of the averaging and hysteresis logic predicts every
// decision. Directed items cover the average corner cases and the pinned
// modes. Random bursts then steer the averages across the MTU and drain
// thresholds under several register settings, idle patterns and a long
// output hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [awcp_pkg::SizeWidth-1:0]   size_type;
   typedef logic [awcp_pkg::GapWidth-1:0]    gap_type;
   typedef logic [awcp_pkg::PolWidth-1:0]    pol_type;
   typedef logic [awcp_pkg::ModeWidth-1:0]   mode_type;
   typedef logic [awcp_pkg::MtuWidth-1:0]    mtu_type;
   typedef logic [awcp_pkg::DelayWidth-1:0]  delay_type;
   typedef logic [awcp_pkg::HystWidth-1:0]   hyst_type;
   typedef logic [awcp_pkg::CsrIdxWidth-1:0] csr_idx_type;
   typedef logic [awcp_pkg::CsrWidth-1:0]    csr_type;

   typedef struct packed {
      pol_type policy;
      pol_type previous_policy;
      logic    transitioned;
   } decision_type;

   // DUT connections
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = awcp_pkg::KIND_OBSERVE;
   size_type    req_write_bytes = '0;
   gap_type     req_gap_micros = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   pol_type     rsp_policy;
   pol_type     rsp_previous_policy;
   logic        rsp_transitioned;
   logic        csr_wr_en = 1'b0;
   csr_idx_type csr_index = awcp_pkg::CSR_MODE;
   csr_type     csr_data = '0;

   // Predicted register file and policy state
   mode_type    cfg_mode;
   mtu_type     cfg_mtu;
   delay_type   cfg_delay;
   hyst_type    cfg_hyst;
   size_type    avg_size;
   gap_type     avg_gap;
   pol_type     cur_pol;
   pol_type     pend_pol;
   hyst_type    streak;

   decision_type decision_q[$];

   int error_count   = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int long_hold     = 0;
   int hold_left     = 0;

   adaptive_write_coalesce_policy dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_write_bytes     (req_write_bytes),
      .req_gap_micros      (req_gap_micros),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_policy          (rsp_policy),
      .rsp_previous_policy (rsp_previous_policy),
      .rsp_transitioned    (rsp_transitioned),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Policy prediction
   // ------------------------------------------------------------------------
   function automatic void reset_policy_model();
      cfg_mode  = awcp_pkg::RST_MODE;
      cfg_mtu   = awcp_pkg::RST_MTU;
      cfg_delay = awcp_pkg::RST_DLY;
      cfg_hyst  = awcp_pkg::RST_HYST;
      avg_size  = '0;
      avg_gap   = '0;
      cur_pol   = awcp_pkg::POL_BATCH;
      pend_pol  = awcp_pkg::POL_BATCH;
      streak    = '0;
   endfunction

   // avg + floor((sample - avg) / 8), clamped to [0, ceiling]
   function automatic gap_type ewma_next(input gap_type avg,
                                         input gap_type sample,
                                         input gap_type ceiling);
      longint diff;
      longint stepped;
      diff    = longint'({32'd0, sample}) - longint'({32'd0, avg});
      stepped = longint'({32'd0, avg}) + (diff >>> awcp_pkg::EwmaShift);
      if (stepped < 0) stepped = 0;
      if (stepped > longint'({32'd0, ceiling})) stepped = longint'({32'd0, ceiling});
      return stepped[awcp_pkg::GapWidth-1:0];
   endfunction

   // Advance the policy state by one accepted item; decisions are queued
   function automatic void track_item(input logic     kind,
                                      input size_type bytes,
                                      input gap_type  gap);
      gap_type sized;
      pol_type prev;
      pol_type pol;
      pol_type cand;
      logic    moved;
      if (kind == awcp_pkg::KIND_OBSERVE) begin
         // empty average loads the raw sample; zero gap is no sample
         if (avg_size == '0) begin
            avg_size = bytes;
         end else begin
            sized    = ewma_next({8'd0, avg_size}, {8'd0, bytes}, 32'h00FF_FFFF);
            avg_size = sized[awcp_pkg::SizeWidth-1:0];
         end
         if (gap != '0) begin
            if (avg_gap == '0) avg_gap = gap;
            else avg_gap = ewma_next(avg_gap, gap, '1);
         end
         return;
      end
      prev  = cur_pol;
      pol   = prev;
      moved = 1'b0;
      case (cfg_mode)
         awcp_pkg::MODE_FIXED: begin
            pol     = awcp_pkg::POL_BATCH;
            cur_pol = pol;
         end
         awcp_pkg::MODE_BYPASS: begin
            pol     = awcp_pkg::POL_BYPASS;
            cur_pol = pol;
         end
         awcp_pkg::MODE_DRAIN: begin
            pol     = awcp_pkg::POL_DRAIN;
            cur_pol = pol;
         end
         default: begin
            if (avg_size >= cfg_mtu) begin
               cand = awcp_pkg::POL_BYPASS;
            end else if (64'(avg_gap) > (64'(cfg_delay) << awcp_pkg::GapFactorShift)) begin
               cand = awcp_pkg::POL_DRAIN;
            end else begin
               cand = awcp_pkg::POL_BATCH;
            end
            if (cand == prev) begin
               streak = '0;
            end else if (cand != pend_pol) begin
               pend_pol = cand;
               streak   = 4'd1;
            end else begin
               if (streak < awcp_pkg::STREAK_MAX) streak = streak + 4'd1;
               if (streak >= cfg_hyst) begin
                  pol     = cand;
                  cur_pol = cand;
                  moved   = 1'b1;
                  streak  = '0;
               end
            end
         end
      endcase
      decision_q.push_back('{pol, prev, moved});
   endfunction

   // ------------------------------------------------------------------------
   // Result side: stall generation and checking
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (long_hold > 0) begin
         hold_left = long_hold;
         long_hold = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns mismatch: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      decision_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (decision_q.size() == 0) begin
            report_mismatch("decision with none pending, policy", int'(rsp_policy), -1);
         end else begin
            want = decision_q.pop_front();
            if (rsp_policy !== want.policy)
               report_mismatch("policy", int'(rsp_policy), int'(want.policy));
            if (rsp_previous_policy !== want.previous_policy)
               report_mismatch("previous_policy", int'(rsp_previous_policy),
                               int'(want.previous_policy));
            if (rsp_transitioned !== want.transitioned)
               report_mismatch("transitioned", int'(rsp_transitioned),
                               int'(want.transitioned));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------
   // One input transfer, with an optional random idle stretch in front
   task automatic send_item(input logic     kind,
                            input size_type bytes,
                            input gap_type  gap);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_write_bytes <= bytes;
      req_gap_micros  <= gap;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_item(kind, bytes, gap);
   endtask

   // Drop valid, collect every pending decision, then let the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (decision_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write; bits above the register width carry junk
   task automatic csr_write(input csr_idx_type idx,
                            input csr_type     value);
      csr_type keep;
      csr_type data;
      case (idx)
         awcp_pkg::CSR_MODE: keep = csr_type'((1 << awcp_pkg::ModeWidth) - 1);
         awcp_pkg::CSR_MTU:  keep = csr_type'((1 << awcp_pkg::MtuWidth) - 1);
         awcp_pkg::CSR_DLY:  keep = '1;
         default:            keep = csr_type'((1 << awcp_pkg::HystWidth) - 1);
      endcase
      data = (csr_type'($urandom()) & ~keep) | (value & keep);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         awcp_pkg::CSR_MODE: cfg_mode  = data[awcp_pkg::ModeWidth-1:0];
         awcp_pkg::CSR_MTU:  cfg_mtu   = data[awcp_pkg::MtuWidth-1:0];
         awcp_pkg::CSR_DLY:  cfg_delay = data[awcp_pkg::DelayWidth-1:0];
         default:            cfg_hyst  = data[awcp_pkg::HystWidth-1:0];
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input mode_type  mode,
                            input mtu_type   mtu,
                            input delay_type delay,
                            input hyst_type  hyst);
      wait_idle();
      csr_write(awcp_pkg::CSR_MODE, csr_type'(mode));
      csr_write(awcp_pkg::CSR_MTU,  csr_type'(mtu));
      csr_write(awcp_pkg::CSR_DLY,  csr_type'(delay));
      csr_write(awcp_pkg::CSR_HYST, csr_type'(hyst));
   endtask

   // Decide item with random filler in the unused fields
   task automatic send_decide();
      send_item(awcp_pkg::KIND_DECIDE, size_type'($urandom()), $urandom());
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Average corner cases under reset settings, ending in drain and bypass
   task automatic test_average_tracking();
      send_item(awcp_pkg::KIND_OBSERVE, '0, '0);        // zero size into empty average
      send_decide();
      send_item(awcp_pkg::KIND_OBSERVE, 24'd1, 32'd1);  // load both averages
      send_item(awcp_pkg::KIND_OBSERVE, '0, '0);        // size falls to zero, gap kept
      send_item(awcp_pkg::KIND_OBSERVE, 24'd5, 32'd7);  // size reloads from raw sample
      send_item(awcp_pkg::KIND_OBSERVE, '0, '1);        // gap jumps past drain threshold
      repeat (3) send_decide();
      send_item(awcp_pkg::KIND_OBSERVE, '1, '1);
      repeat (3) send_decide();
   endtask

   // Forced policies, then back to adaptive with the shortest hysteresis
   task automatic test_pinned_modes();
      configure(awcp_pkg::MODE_FIXED, awcp_pkg::RST_MTU, awcp_pkg::RST_DLY,
                awcp_pkg::RST_HYST);
      send_decide();
      configure(awcp_pkg::MODE_BYPASS, 16'hFFFF, 24'hFF_FFFF, awcp_pkg::RST_HYST);
      send_decide();
      configure(awcp_pkg::MODE_DRAIN, 16'h0000, 24'h00_0000, awcp_pkg::RST_HYST);
      send_decide();
      configure(awcp_pkg::MODE_ADAPTIVE, awcp_pkg::RST_MTU, awcp_pkg::RST_DLY, 4'd1);
      repeat (3) send_decide();
   endtask

   // Receiver holds off for a long stretch while decisions keep coming
   task automatic test_output_backpressure();
      configure(awcp_pkg::MODE_ADAPTIVE, awcp_pkg::RST_MTU, awcp_pkg::RST_DLY, 4'd2);
      send_idle_pct = 0;
      stall_pct     = 0;
      long_hold     = 200;
      repeat (30) begin
         send_item(($urandom_range(3) != 0) ? awcp_pkg::KIND_DECIDE
                                            : awcp_pkg::KIND_OBSERVE,
                   size_type'($urandom()), $urandom());
      end
      wait_idle();
   endtask

   // Bursts that steer the averages toward a target, then decision runs
   task automatic test_random_traffic();
      int       done;
      int       n_obs;
      int       n_dec;
      size_type size_tgt;
      gap_type  gap_tgt;
      gap_type  gap_limit;
      gap_type  gap;
      int       gap_pick;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: configure(awcp_pkg::MODE_ADAPTIVE, awcp_pkg::RST_MTU, awcp_pkg::RST_DLY,
                         awcp_pkg::RST_HYST);
            1: configure(awcp_pkg::MODE_ADAPTIVE, 16'h0000, delay_type'($urandom()), 4'd1);
            2: configure(awcp_pkg::MODE_ADAPTIVE, 16'hFFFF, 24'h00_0000, 4'd15);
            3: configure(awcp_pkg::MODE_ADAPTIVE, 16'hFFFF, 24'hFF_FFFF,
                         hyst_type'($urandom_range(15, 1)));
            4: configure(awcp_pkg::MODE_FIXED, mtu_type'($urandom()),
                         delay_type'($urandom()), hyst_type'($urandom_range(15, 1)));
            5: configure(awcp_pkg::MODE_BYPASS, mtu_type'($urandom()),
                         delay_type'($urandom()), hyst_type'($urandom_range(15, 1)));
            6: configure(awcp_pkg::MODE_DRAIN, mtu_type'($urandom()),
                         delay_type'($urandom()), hyst_type'($urandom_range(15, 1)));
            default: configure(awcp_pkg::MODE_ADAPTIVE, mtu_type'($urandom()),
                               delay_type'($urandom()), hyst_type'($urandom_range(15, 1)));
         endcase
         // idle profile: none, sender, receiver, both
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         gap_limit = {6'd0, cfg_delay, 2'b00};
         done = 0;
         while (done < 93) begin
            if ($urandom_range(4) == 0) begin
               // noise: unrelated items with every field random
               n_obs = $urandom_range(6, 1);
               repeat (n_obs) begin
                  send_item(1'($urandom_range(1)), size_type'($urandom()), $urandom());
               end
               done += n_obs;
            end else begin
               case ($urandom_range(3))
                  0: size_tgt = size_type'($urandom_range(cfg_mtu));
                  1: size_tgt = size_type'($urandom_range(32'h00FF_FFFF, cfg_mtu));
                  2: size_tgt = {8'd0, cfg_mtu} ^ size_type'($urandom_range(31));
                  default: size_tgt = size_type'($urandom());
               endcase
               gap_pick = $urandom_range(3);
               case (gap_pick)
                  0: gap_tgt = '0;
                  1: gap_tgt = $urandom_range(gap_limit);
                  2: gap_tgt = $urandom_range(32'hFFFF_FFFF, gap_limit);
                  default: gap_tgt = $urandom();
               endcase
               n_obs = $urandom_range(10);
               n_dec = $urandom_range(18, 1);
               repeat (n_obs) begin
                  gap = gap_tgt ^ gap_type'($urandom_range(7));
                  if (gap_pick == 0 || $urandom_range(9) == 0) gap = '0;
                  send_item(awcp_pkg::KIND_OBSERVE,
                            size_tgt ^ size_type'($urandom_range(7)), gap);
               end
               repeat (n_dec) send_decide();
               done += n_obs + n_dec;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset_policy_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_average_tracking();
      test_pinned_modes();
      test_output_backpressure();
      test_random_traffic();
      wait_idle();
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
